### rtl/bba_pkg.sv
// Shared types and constants for the bounding box accumulator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int COORD_W = 24;
  localparam int NUM_AXES = 3;
  localparam int AXIS_W = $clog2(NUM_AXES + 1);
  localparam int DIFF_W = COORD_W;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int ITER_W = $clog2(ROOT_W + 1);

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   req_type;
    coord_t vx;
    coord_t vy;
    coord_t vz;
  } in_req_t;

  typedef struct packed {
    logic               box_valid;
    coord_t             lo_x;
    coord_t             lo_y;
    coord_t             lo_z;
    coord_t             hi_x;
    coord_t             hi_y;
    coord_t             hi_z;
    coord_t             mid_x;
    coord_t             mid_y;
    coord_t             mid_z;
    logic [COORD_W-1:0] half_diagonal;
  } out_res_t;

  typedef struct packed {
    logic              vtx_en;
    logic              fin_load;
    logic              mul_en;
    logic [AXIS_W-1:0] mul_idx;
    logic              acc_en;
    logic              sqrt_start;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } dp_status_t;

endpackage

### rtl/bba_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module bba_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bba_pkg::SUM_W-1:0]  radicand,
  output logic                       done,
  output logic [bba_pkg::ROOT_W-1:0] root
);
  import bba_pkg::*;

  logic [SUM_W-1:0]  n_r, n_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_r[REM_W-3:0], n_r[SUM_W-1:SUM_W-2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = ITER_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt    = {n_r[SUM_W-3:0], 2'b00};
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], fits};
      cnt_nxt  = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/bba_datapath.sv
// Datapath: running box registers, squared diagonal, square root and result register.
`timescale 1ns / 1ps
module bba_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bba_pkg::in_req_t     in_data,
  input  bba_pkg::ctrl_cmd_t   cmd,
  output bba_pkg::dp_status_t  status,
  output bba_pkg::out_res_t    out_data
);
  import bba_pkg::*;

  logic                  seen_r, seen_nxt;
  coord_t                lo_r  [NUM_AXES];
  coord_t                hi_r  [NUM_AXES];
  coord_t                lo_nxt[NUM_AXES];
  coord_t                hi_nxt[NUM_AXES];
  coord_t                vin   [NUM_AXES];
  coord_t                mid   [NUM_AXES];
  logic [DIFF_W-1:0]     diff_r[NUM_AXES];
  logic [DIFF_W-1:0]     mul_op;
  logic [PROD_W-1:0]     prod_r;
  logic [SUM_W-1:0]      sum_r;
  logic [ROOT_W-1:0]     root;
  logic                  sqrt_done;
  out_res_t              out_r;

  assign vin[0] = in_data.vx;
  assign vin[1] = in_data.vy;
  assign vin[2] = in_data.vz;

  always_comb begin
    seen_nxt = seen_r;
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_nxt[i] = lo_r[i];
      hi_nxt[i] = hi_r[i];
    end
    if (cmd.out_load) begin
      seen_nxt = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo_nxt[i] = '0;
        hi_nxt[i] = '0;
      end
    end else if (cmd.vtx_en) begin
      seen_nxt = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (!seen_r || (vin[i] < lo_r[i])) begin
          lo_nxt[i] = vin[i];
        end
        if (!seen_r || (vin[i] > hi_r[i])) begin
          hi_nxt[i] = vin[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo_r[i] <= lo_nxt[i];
        hi_r[i] <= hi_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mid[i] = coord_t'(({hi_r[i][COORD_W-1], hi_r[i]} + {lo_r[i][COORD_W-1], lo_r[i]})
                        >> 1);
    end
  end

  always_comb begin
    case (cmd.mul_idx)
      AXIS_W'(0): mul_op = diff_r[0];
      AXIS_W'(1): mul_op = diff_r[1];
      AXIS_W'(2): mul_op = diff_r[2];
      default:    mul_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        diff_r[i] <= DIFF_W'({hi_r[i][COORD_W-1], hi_r[i]} - {lo_r[i][COORD_W-1], lo_r[i]});
      end
    end
    if (cmd.mul_en) begin
      prod_r <= mul_op * mul_op;
    end
    if (cmd.fin_load) begin
      sum_r <= '0;
    end else if (cmd.acc_en) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_r.box_valid     <= seen_r;
      out_r.lo_x          <= lo_r[0];
      out_r.lo_y          <= lo_r[1];
      out_r.lo_z          <= lo_r[2];
      out_r.hi_x          <= hi_r[0];
      out_r.hi_y          <= hi_r[1];
      out_r.hi_z          <= hi_r[2];
      out_r.mid_x         <= mid[0];
      out_r.mid_y         <= mid[1];
      out_r.mid_z         <= mid[2];
      out_r.half_diagonal <= root[ROOT_W-1:1];
    end
  end

  bba_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (root)
  );

  assign status.sqrt_done = sqrt_done;
  assign out_data         = out_r;

endmodule

### rtl/bba_ctrl.sv
// Controller: request handshakes and sequencing of the finish computation.
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bba_pkg::dp_status_t  status,
  output bba_pkg::ctrl_cmd_t   cmd
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQ    = 5'b00010,
    S_START = 5'b00100,
    S_ROOT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic [AXIS_W-1:0] SQ_LAST = AXIS_W'(NUM_AXES);

  state_t            state_r, state_nxt;
  logic [AXIS_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_FINISH) begin
            cmd.fin_load = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_SQ;
          end else begin
            cmd.vtx_en = 1'b1;
          end
        end
      end
      S_SQ: begin
        cmd.mul_idx = cnt_r;
        cmd.mul_en  = (cnt_r != SQ_LAST);
        cmd.acc_en  = (cnt_r != '0);
        cnt_nxt     = cnt_r + AXIS_W'(1);
        if (cnt_r == SQ_LAST) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (status.sqrt_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/bounding_box_accumulator_top.sv
// Top level of the 3D axis-aligned bounding box accumulator.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   bba_pkg::in_req_t (vertex or finish)
//   out_     output     out_valid / out_stall bba_pkg::out_res_t (one per finish)
//
// Vertices stream at one per cycle while no finish request holds the input.
// A finish request holds the input stalled while it runs the shared squaring
// multiplier over the three axes, starts the root, runs the bit-serial square
// root (25 steps and its done flag) and loads the result register; the result
// shows in the cycle after that load.
// A result waiting under out_stall does not block vertices; a following finish
// waits in its last step until the result register is free.
// Reset clears the box and all control state; no clearing pass is needed.
`timescale 1ns / 1ps
module bounding_box_accumulator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bba_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bba_pkg::out_res_t  out_data
);
  import bba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bba_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

### test/tb_bounding_box_accumulator_top.sv
// Self-checking testbench for the bounding box accumulator with its own box predictor.
`timescale 1ns / 1ps
module tb_bounding_box_accumulator_top;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1050;
  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;

  typedef struct {
    in_req_t req;
    bit      drain;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_res_t  out_data;

  queued_req_t req_queue[$];
  out_res_t    box_results_due[$];
  int          n_queued = 0;
  int          cycle_count = 0;
  int          n_errors = 0;
  int          n_vertices = 0;
  int          n_finishes = 0;
  int          n_empty = 0;
  int          n_checked = 0;
  logic        in_taken = 1'b0;
  logic        calm;

  bit          box_seen = 1'b0;
  coord_t      box_lo[3] = '{default: '0};
  coord_t      box_hi[3] = '{default: '0};

  bounding_box_accumulator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (cycle_count >= 2000) && (cycle_count < 3500);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return coord_t'($signed($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic queue_request(input req_type_t kind, input coord_t x, input coord_t y,
                               input coord_t z);
    queued_req_t item;
    item.req.req_type = kind;
    item.req.vx = x;
    item.req.vy = y;
    item.req.vz = z;
    item.drain = (n_queued == 20) || (n_queued == 600);
    req_queue.push_back(item);
    n_queued++;
  endtask

  // Folds one accepted request into the box and returns the result a finish emits.
  function automatic void fold_request(input in_req_t r, output bit emits,
                                       output out_res_t res);
    coord_t             v[3];
    coord_t             mid[3];
    logic signed [24:0] s;
    logic [63:0]        d;
    logic [63:0]        sq_sum;
    logic [63:0]        root;
    logic [63:0]        trial;
    int                 a;
    int                 b;
    v[0] = r.vx;
    v[1] = r.vy;
    v[2] = r.vz;
    emits = 1'b0;
    res = '0;
    if (r.req_type == REQ_VERTEX) begin
      for (a = 0; a < 3; a++) begin
        if (!box_seen) begin
          box_lo[a] = v[a];
          box_hi[a] = v[a];
        end else begin
          if (v[a] < box_lo[a]) box_lo[a] = v[a];
          if (v[a] > box_hi[a]) box_hi[a] = v[a];
        end
      end
      box_seen = 1'b1;
    end else begin
      emits = 1'b1;
      if (box_seen) begin
        sq_sum = '0;
        for (a = 0; a < 3; a++) begin
          s = {box_hi[a][23], box_hi[a]} - {box_lo[a][23], box_lo[a]};
          d = {39'b0, s};
          sq_sum += d * d;
          s = {box_lo[a][23], box_lo[a]} + {box_hi[a][23], box_hi[a]};
          mid[a] = s[24:1];
        end
        root = '0;
        for (b = 25; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= sq_sum) root = trial;
        end
        res.box_valid = 1'b1;
        res.lo_x = box_lo[0];
        res.lo_y = box_lo[1];
        res.lo_z = box_lo[2];
        res.hi_x = box_hi[0];
        res.hi_y = box_hi[1];
        res.hi_z = box_hi[2];
        res.mid_x = mid[0];
        res.mid_y = mid[1];
        res.mid_z = mid[2];
        res.half_diagonal = root[24:1];
      end
      box_seen = 1'b0;
      for (a = 0; a < 3; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(negedge clk) begin
    bit send;
    queued_req_t item;
    if (rst_n && (!in_valid || in_taken)) begin
      send = (req_queue.size() != 0) && (calm || ($urandom_range(0, 99) >= 26));
      if (send && req_queue[0].drain && (box_results_due.size() != 0)) send = 1'b0;
      if (send) begin
        item = req_queue.pop_front();
        in_data <= item.req;
      end
      in_valid <= send;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk) begin
    out_res_t want;
    bit emits;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (box_results_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_data);
          n_errors++;
        end else begin
          want = box_results_due.pop_front();
          check_field("box_valid", {23'b0, want.box_valid}, {23'b0, out_data.box_valid});
          check_field("lo_x", want.lo_x, out_data.lo_x);
          check_field("lo_y", want.lo_y, out_data.lo_y);
          check_field("lo_z", want.lo_z, out_data.lo_z);
          check_field("hi_x", want.hi_x, out_data.hi_x);
          check_field("hi_y", want.hi_y, out_data.hi_y);
          check_field("hi_z", want.hi_z, out_data.hi_z);
          check_field("mid_x", want.mid_x, out_data.mid_x);
          check_field("mid_y", want.mid_y, out_data.mid_y);
          check_field("mid_z", want.mid_z, out_data.mid_z);
          check_field("half_diagonal", want.half_diagonal, out_data.half_diagonal);
          n_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        fold_request(in_data, emits, want);
        if (emits) begin
          box_results_due.push_back(want);
          n_finishes++;
          if (!want.box_valid) n_empty++;
        end else begin
          n_vertices++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, box_results_due.size());
    $display("tb_bounding_box_accumulator_top: FAIL");
    $finish;
  end

  initial begin
    int kind;
    int nv;
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_VERTEX, C_MAX, C_MAX, C_MAX);
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_VERTEX, C_MIN, C_MIN, C_MIN);
    queue_request(REQ_VERTEX, C_MAX, C_MAX, C_MAX);
    queue_request(REQ_FINISH, C_MAX, C_MIN, C_MAX);
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_VERTEX, C_MAX, C_MIN, '0);
    queue_request(REQ_VERTEX, C_MIN, C_MAX, -24'sd1);
    queue_request(REQ_VERTEX, '0, '0, C_MAX);
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_VERTEX, -24'sd1, -24'sd1, -24'sd1);
    queue_request(REQ_VERTEX, '0, '0, '0);
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_VERTEX, 24'sd1, -24'sd1, 24'sd3);
    queue_request(REQ_VERTEX, 24'sd2, -24'sd4, -24'sd3);
    queue_request(REQ_FINISH, '0, '0, '0);
    queue_request(REQ_FINISH, -24'sd1, -24'sd1, -24'sd1);

    // Mostly complete boxes of random size, with stray empty finishes mixed in.
    while (n_queued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind >= 8) begin
        nv = (kind < 15) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (nv) queue_request(REQ_VERTEX, rand_coord(), rand_coord(), rand_coord());
      end
      queue_request(REQ_FINISH, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_valid || box_results_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests: %0d vertices and %0d finishes, %0d of them on empty boxes.",
             n_vertices + n_finishes, n_vertices, n_finishes, n_empty);
    $display("Checked %0d box results field by field, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && box_results_due.size() == 0) begin
      $display("tb_bounding_box_accumulator_top: PASS");
    end else begin
      $display("tb_bounding_box_accumulator_top: FAIL");
    end
    $finish;
  end

endmodule
